@@ rtl/core/usp_pkg.sv @@
// ----------------------------------------------------------------------------
// usp_pkg
// Shared types and constants for the USB audio OUT stream unpacker.
// ----------------------------------------------------------------------------
package usp_pkg;

    localparam int unsigned MAX_PACKET_WORDS_DEF = 512;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STREAM_ALT  = 3'd0,
        CFG_SAMPLE_FMT  = 3'd1,
        CFG_EAC3_ALT    = 3'd2,
        CFG_AC3_ALT     = 3'd3,
        CFG_PCM_MAX     = 3'd4,
        CFG_IEC_MAX     = 3'd5,
        CFG_EAC3_MAX    = 3'd6
    } t_cfg_idx;

    // sample_format codes; the unused codes decode as 32-bit
    localparam logic [1:0] FMT_16 = 2'd0;
    localparam logic [1:0] FMT_24 = 2'd1;

    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    localparam logic RES_STATUS = 1'b0;
    localparam logic RES_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_CLOSED = 2'd1,
        ST_BAD    = 2'd2
    } t_status;

    localparam logic [2:0]  RST_STREAM_ALT = 3'd0;
    localparam logic [1:0]  RST_SAMPLE_FMT = 2'd0;
    localparam logic [2:0]  RST_EAC3_ALT   = 3'd5;
    localparam logic [2:0]  RST_AC3_ALT    = 3'd4;
    localparam logic [11:0] RST_PCM_MAX    = 12'd1024;
    localparam logic [11:0] RST_IEC_MAX    = 12'd1024;
    localparam logic [11:0] RST_EAC3_MAX   = 12'd2048;

    typedef struct packed {
        logic [2:0]  stream_alt;
        logic [1:0]  sample_format;
        logic [2:0]  eac3_alt;
        logic [2:0]  ac3_alt;
        logic [11:0] pcm_max;
        logic [11:0] iec_max;
        logic [11:0] eac3_max;
    } t_cfg;

    // results caused by one input item (at most two)
    typedef struct packed {
        logic        valid;
        logic        two;
        logic        kind;
        t_status     status;
        logic [31:0] sample0;
        logic [31:0] sample1;
        logic        last0;
        logic        last1;
    } t_bundle;

endpackage

@@ rtl/core/usp_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// usp_cfg_regs
// Configuration register file with write-only access.
// ----------------------------------------------------------------------------
module usp_cfg_regs import usp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stream_alt    <= RST_STREAM_ALT;
            r_cfg.sample_format <= RST_SAMPLE_FMT;
            r_cfg.eac3_alt      <= RST_EAC3_ALT;
            r_cfg.ac3_alt       <= RST_AC3_ALT;
            r_cfg.pcm_max       <= RST_PCM_MAX;
            r_cfg.iec_max       <= RST_IEC_MAX;
            r_cfg.eac3_max      <= RST_EAC3_MAX;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_STREAM_ALT: r_cfg.stream_alt    <= i_cfg_wdata[2:0];
                CFG_SAMPLE_FMT: r_cfg.sample_format <= i_cfg_wdata[1:0];
                CFG_EAC3_ALT:   r_cfg.eac3_alt      <= i_cfg_wdata[2:0];
                CFG_AC3_ALT:    r_cfg.ac3_alt       <= i_cfg_wdata[2:0];
                CFG_PCM_MAX:    r_cfg.pcm_max       <= i_cfg_wdata;
                CFG_IEC_MAX:    r_cfg.iec_max       <= i_cfg_wdata;
                CFG_EAC3_MAX:   r_cfg.eac3_max      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/core/usp_parser.sv @@
// ----------------------------------------------------------------------------
// usp_parser
// Packet start check, counters and word unpacking for one accepted item.
// ----------------------------------------------------------------------------
module usp_parser import usp_pkg::*; #(
    parameter int unsigned MAX_PACKET_WORDS = MAX_PACKET_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_take,
    input  logic        i_kind,
    input  logic [15:0] i_packet_length,
    input  logic [31:0] i_data_word,
    output t_bundle     o_bundle,
    output logic [31:0] o_bad_packet_count,
    output logic [31:0] o_rx_packet_count,
    output logic [31:0] o_rx_frame_count
);

    localparam int unsigned WCW       = $clog2(MAX_PACKET_WORDS + 1);
    localparam int unsigned LEN_LIMIT = MAX_PACKET_WORDS * 4;

    logic [WCW-1:0] r_words, n_words;
    logic [31:0]    r_bad, n_bad;
    logic [31:0]    r_pkts, n_pkts;
    logic [31:0]    r_frames, n_frames;

    logic [11:0]    max_pkt;
    logic           fmt16;
    logic           len_bad;
    logic [15:0]    frames;
    logic           last;
    t_bundle        bundle;

    always_comb begin
        priority if (i_cfg.stream_alt == i_cfg.eac3_alt) begin
            max_pkt = i_cfg.eac3_max;
        end else if (i_cfg.stream_alt >= i_cfg.ac3_alt) begin
            max_pkt = i_cfg.iec_max;
        end else begin
            max_pkt = i_cfg.pcm_max;
        end
    end

    assign fmt16   = (i_cfg.sample_format == FMT_16);
    assign len_bad = (i_packet_length > {4'd0, max_pkt})
                   || (i_packet_length[1:0] != 2'd0)
                   || (!fmt16 && i_packet_length[2])
                   || ({16'd0, i_packet_length} > 32'(LEN_LIMIT));
    assign frames  = fmt16 ? {2'd0, i_packet_length[15:2]}
                           : {3'd0, i_packet_length[15:3]};
    assign last    = (r_words == WCW'(1));

    always_comb begin
        n_words  = r_words;
        n_bad    = r_bad;
        n_pkts   = r_pkts;
        n_frames = r_frames;
        bundle   = '0;
        if (i_take) begin
            if (i_kind == KIND_START) begin
                n_words      = '0;
                bundle.valid = 1'b1;
                bundle.kind  = RES_STATUS;
                priority if (i_cfg.stream_alt == 3'd0) begin
                    bundle.status = ST_CLOSED;
                end else if (len_bad) begin
                    bundle.status = ST_BAD;
                    n_bad         = r_bad + 32'd1;
                end else begin
                    bundle.status = ST_OK;
                    n_pkts        = r_pkts + 32'd1;
                    n_frames      = r_frames + {16'd0, frames};
                    // length is within the buffer here, so the count fits
                    n_words       = i_packet_length[WCW+1:2];
                end
            end else if (r_words != '0) begin
                n_words      = r_words - WCW'(1);
                bundle.valid = 1'b1;
                bundle.kind  = RES_SAMPLE;
                bundle.status = ST_OK;
                priority if (fmt16) begin
                    bundle.two     = 1'b1;
                    bundle.sample0 = {{16{i_data_word[15]}}, i_data_word[15:0]};
                    bundle.sample1 = {{16{i_data_word[31]}}, i_data_word[31:16]};
                    bundle.last1   = last;
                end else if (i_cfg.sample_format == FMT_24) begin
                    bundle.sample0 = {{8{i_data_word[31]}}, i_data_word[31:8]};
                    bundle.last0   = last;
                end else begin
                    bundle.sample0 = i_data_word;
                    bundle.last0   = last;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words  <= '0;
            r_bad    <= '0;
            r_pkts   <= '0;
            r_frames <= '0;
        end else begin
            r_words  <= n_words;
            r_bad    <= n_bad;
            r_pkts   <= n_pkts;
            r_frames <= n_frames;
        end
    end

    assign o_bundle           = bundle;
    assign o_bad_packet_count = r_bad;
    assign o_rx_packet_count  = r_pkts;
    assign o_rx_frame_count   = r_frames;

endmodule

@@ rtl/core/usp_result_buf.sv @@
// ----------------------------------------------------------------------------
// usp_result_buf
// Result register; plays out one or two results per item.
// ----------------------------------------------------------------------------
module usp_result_buf import usp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_bundle     i_bundle,
    input  logic        i_ready,
    output logic        o_can_take,
    output logic        o_valid,
    output logic        o_result_kind,
    output logic [1:0]  o_packet_status,
    output logic [31:0] o_sample_value,
    output logic        o_last_sample
);

    logic        r_valid, n_valid;
    logic        r_sel, n_sel;
    t_bundle     r_bnd;
    logic        xfer;
    logic        done;

    assign xfer       = r_valid && i_ready;
    assign done       = xfer && (!r_bnd.two || r_sel);
    assign o_can_take = !r_valid || done;

    always_comb begin
        n_valid = r_valid;
        n_sel   = r_sel;
        if (xfer) begin
            if (done) begin
                n_valid = 1'b0;
                n_sel   = 1'b0;
            end else begin
                n_sel = 1'b1;
            end
        end
        if (i_bundle.valid) begin
            n_valid = 1'b1;
            n_sel   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sel   <= n_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_bundle.valid) begin
            r_bnd <= i_bundle;
        end
    end

    assign o_valid         = r_valid;
    assign o_result_kind   = r_bnd.kind;
    assign o_packet_status = r_bnd.status;
    assign o_sample_value  = r_sel ? r_bnd.sample1 : r_bnd.sample0;
    assign o_last_sample   = r_sel ? r_bnd.last1 : r_bnd.last0;

endmodule

@@ rtl/core/usb_audio_stream_unpacker_top.sv @@
// ----------------------------------------------------------------------------
// usb_audio_stream_unpacker_top
// USB audio OUT packet unpacker: start items are checked and counted,
// payload words are split into signed samples.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready): a start item (kind 0) carries the packet
// length, payload items (kind 1) carry one 32-bit word each.
// Output channel (o_valid/i_ready): one status result per start item, one
// sample per payload word (two in 16-bit mode, left then right). Stray words
// give no result. The three counters on the output show the values after
// the item that caused the result.
// A result is registered and appears in the cycle after its item transfer.
// Throughput: one item per cycle while the receiver is ready; a 16-bit payload
// word stays in the one-sample-per-cycle output register until the pair is out.
// The next item is taken in the cycle the last pending result leaves.
// Receiver stall: the result register holds, and o_ready drops until it
// drains. Reset: configuration returns to defaults, counters and the open
// packet clear, the output goes empty. The user must write configuration
// through i_cfg_we/i_cfg_index/i_cfg_wdata while the block is idle (the block does not enforce it).
// ----------------------------------------------------------------------------
module usb_audio_stream_unpacker_top import usp_pkg::*; #(
    parameter int unsigned MAX_PACKET_WORDS = MAX_PACKET_WORDS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_kind,
    input  logic [15:0]           i_packet_length,
    input  logic [31:0]           i_data_word,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_result_kind,
    output logic [1:0]            o_packet_status,
    output logic signed [31:0]    o_sample_value,
    output logic                  o_last_sample,
    output logic [31:0]           o_bad_packet_count,
    output logic [31:0]           o_rx_packet_count,
    output logic [31:0]           o_rx_frame_count
);

    t_cfg        cfg;
    t_bundle     bundle;
    logic        can_take;
    logic        take;
    logic [31:0] sample;

    assign o_ready = can_take;
    assign take    = i_valid && can_take;

    usp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    usp_parser #(
        .MAX_PACKET_WORDS (MAX_PACKET_WORDS)
    ) u_parser (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (cfg),
        .i_take             (take),
        .i_kind             (i_kind),
        .i_packet_length    (i_packet_length),
        .i_data_word        (i_data_word),
        .o_bundle           (bundle),
        .o_bad_packet_count (o_bad_packet_count),
        .o_rx_packet_count  (o_rx_packet_count),
        .o_rx_frame_count   (o_rx_frame_count)
    );

    usp_result_buf u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_bundle        (bundle),
        .i_ready         (i_ready),
        .o_can_take      (can_take),
        .o_valid         (o_valid),
        .o_result_kind   (o_result_kind),
        .o_packet_status (o_packet_status),
        .o_sample_value  (sample),
        .o_last_sample   (o_last_sample)
    );

    assign o_sample_value = $signed(sample);

endmodule
